// ===== rtl/core/anbs_pkg.sv =====
// Shared types and constants for the Annex B NAL unit splitter.
// No dependencies; all rtl/core files but anbs_cfg_if use it by scoped names.

package anbs_pkg;

    localparam int BYTE_W    = 8;
    localparam int TYPE_W    = 5;
    localparam int LEN_OUT_W = 16;
    localparam int WIN_DEPTH = 5;
    localparam int CNT_W     = 3;
    localparam int EVQ_DEPTH = 2;
    localparam int EVQ_PTR_W = 1;

    localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;
    localparam logic [BYTE_W-1:0] ONE_BYTE  = 8'h01;
    localparam logic [TYPE_W-1:0] TYPE_MASK = 5'h1f;

    localparam logic [CNT_W-1:0] LEN_CODE3 = 3'd3;
    localparam logic [CNT_W-1:0] LEN_CODE4 = 3'd4;
    localparam logic [CNT_W-1:0] LEN_NONE  = 3'd0;

    typedef logic [WIN_DEPTH-1:0][BYTE_W-1:0] win_t;

    typedef struct packed {
        logic              pop;
        logic              strip;
        logic              last_byte;
        logic              end_unit;
        logic [BYTE_W-1:0] data;
    } anbs_evt_t;

endpackage

// ===== rtl/core/anbs_byte_if.sv =====
// Input byte channel of the splitter.
// Depends on anbs_pkg for field widths.

interface anbs_byte_if;
    logic                          valid;
    logic                          ready;
    logic [anbs_pkg::BYTE_W-1:0]   data_byte;
    logic                          end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// ===== rtl/core/anbs_unit_if.sv =====
// Output payload channel of the splitter, one NAL payload byte per beat.
// Depends on anbs_pkg for field widths.

interface anbs_unit_if;
    logic                            valid;
    logic                            ready;
    logic [anbs_pkg::BYTE_W-1:0]     payload_byte;
    logic                            unit_first;
    logic                            unit_last;
    logic [anbs_pkg::TYPE_W-1:0]     unit_type;
    logic [anbs_pkg::LEN_OUT_W-1:0]  unit_length;

    modport source (output valid, output payload_byte, output unit_first, output unit_last,
                    output unit_type, output unit_length, input ready);
    modport sink   (input valid, input payload_byte, input unit_first, input unit_last,
                    input unit_type, input unit_length, output ready);
endinterface

// ===== rtl/core/anbs_cfg_if.sv =====
// Configuration write channel carrying the three_byte_codes mode bit.
// No dependencies.

interface anbs_cfg_if;
    logic valid;
    logic ready;
    logic three_byte_codes;

    modport source (output valid, output three_byte_codes, input ready);
    modport sink   (input valid, input three_byte_codes, output ready);
endinterface

// ===== rtl/core/annexb_nal_unit_splitter.sv =====
// Top level of the Annex B NAL unit splitter: mode register, front end, event queue
// and back end. Depends on anbs_pkg, the three channel interfaces and all anbs_ modules.
//
// Channels: stream takes one Annex B byte per beat with end_of_stream on the final byte;
// units gives one NAL payload byte per beat, tagged with unit_first, unit_last, unit_type
// and a saturating unit_length; cfg writes the three_byte_codes mode bit (always ready).
// Start code bytes and bytes before the first start code produce no beats.
// Throughput: one byte per cycle while the event queue has room. A byte is released once
// four later bytes are held and reaches units via the event queue and output register.
// On an end_of_stream beat the held window drains one event per cycle while the queue
// has room, stream.ready stays low until the window is empty, and the block returns to
// its before-first-start-code state. A stalled units receiver fills the output register
// and the two-entry event queue, after which stream.ready drops; nothing is lost.
// Reset: window emptied, unit state cleared, three_byte_codes cleared to zero.

module annexb_nal_unit_splitter #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    anbs_byte_if.sink   stream,
    anbs_cfg_if.sink    cfg,
    anbs_unit_if.source units
);

    logic                mode_reg;
    logic                q_full;
    logic                q_empty;
    logic                q_push;
    logic                q_pop;
    anbs_pkg::anbs_evt_t evt_wr;
    anbs_pkg::anbs_evt_t evt_rd;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            mode_reg <= cfg.three_byte_codes;
        end
    end

    anbs_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .stream           (stream),
        .three_byte_codes (mode_reg),
        .q_full           (q_full),
        .push             (q_push),
        .evt              (evt_wr)
    );

    anbs_evq u_evq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .evt_in  (evt_wr),
        .pop     (q_pop),
        .full    (q_full),
        .empty   (q_empty),
        .evt_out (evt_rd)
    );

    anbs_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .evt     (evt_rd),
        .q_pop   (q_pop),
        .units   (units)
    );

endmodule

// ===== rtl/core/anbs_front.sv =====
// Front end: accepts stream bytes, holds the lookahead window, finds start codes
// and issues pop, strip and end_unit events. Depends on anbs_pkg and anbs_byte_if.

module anbs_front (
    input  logic                clk,
    input  logic                rst_n,
    anbs_byte_if.sink           stream,
    input  logic                three_byte_codes,
    input  logic                q_full,
    output logic                push,
    output anbs_pkg::anbs_evt_t evt
);

    anbs_pkg::win_t                 win_reg;
    anbs_pkg::win_t                 win_next;
    logic [anbs_pkg::CNT_W-1:0]     cnt_reg;
    logic [anbs_pkg::CNT_W-1:0]     cnt_next;
    logic                           flush_reg;
    logic                           flush_next;

    anbs_pkg::win_t                 bufv;
    anbs_pkg::win_t                 rest;
    logic [anbs_pkg::CNT_W-1:0]     n_in;
    logic [anbs_pkg::CNT_W-1:0]     rn;
    logic [anbs_pkg::CNT_W-1:0]     pre;
    logic [anbs_pkg::CNT_W-1:0]     post;
    logic [anbs_pkg::CNT_W-1:0]     shift;
    logic                           flush_now;
    logic                           do_pop;
    logic                           do_strip;
    logic                           is_last;
    logic                           end_unit;
    logic                           step;

    function automatic logic [anbs_pkg::CNT_W-1:0] code_len(
        input anbs_pkg::win_t             b,
        input logic [anbs_pkg::CNT_W-1:0] n,
        input logic                       three
    );
        logic [anbs_pkg::CNT_W-1:0] len;
        len = anbs_pkg::LEN_NONE;
        if (n >= anbs_pkg::LEN_CODE4 && b[0] == anbs_pkg::ZERO_BYTE &&
            b[1] == anbs_pkg::ZERO_BYTE && b[2] == anbs_pkg::ZERO_BYTE &&
            b[3] == anbs_pkg::ONE_BYTE)
        begin
            len = anbs_pkg::LEN_CODE4;
        end
        else if (three && n >= anbs_pkg::LEN_CODE3 && b[0] == anbs_pkg::ZERO_BYTE &&
                 b[1] == anbs_pkg::ZERO_BYTE && b[2] == anbs_pkg::ONE_BYTE)
        begin
            len = anbs_pkg::LEN_CODE3;
        end
        return len;
    endfunction

    always_comb
    begin
        bufv = win_reg;
        for (int k = 0; k < anbs_pkg::WIN_DEPTH; k++)
        begin
            if (!flush_reg && anbs_pkg::CNT_W'(k) == cnt_reg)
            begin
                bufv[k] = stream.data_byte;
            end
        end
        n_in      = flush_reg ? cnt_reg : cnt_reg + 3'd1;
        flush_now = flush_reg | stream.end_of_stream;
        rest      = bufv >> anbs_pkg::BYTE_W;
        rn        = n_in - 3'd1;
        pre       = code_len(bufv, n_in, three_byte_codes);
        post      = code_len(rest, rn, three_byte_codes);

        do_pop   = 1'b0;
        do_strip = 1'b0;
        is_last  = 1'b0;
        shift    = anbs_pkg::LEN_NONE;
        if (pre != anbs_pkg::LEN_NONE)
        begin
            do_strip = 1'b1;
            shift    = pre;
        end
        else if (n_in == 3'd5 || (flush_now && n_in != 3'd0))
        begin
            do_pop   = 1'b1;
            is_last  = (rn == 3'd0) || (post != anbs_pkg::LEN_NONE);
            do_strip = post != anbs_pkg::LEN_NONE;
            shift    = 3'd1 + post;
        end

        cnt_next   = n_in - shift;
        win_next   = bufv >> {shift, 3'b000};
        end_unit   = flush_now && cnt_next == 3'd0;
        flush_next = flush_now && cnt_next != 3'd0;

        step = !q_full && (flush_reg || stream.valid);
        push = step && (do_pop || do_strip || end_unit);

        evt.pop       = do_pop;
        evt.strip     = do_strip;
        evt.last_byte = is_last;
        evt.end_unit  = end_unit;
        evt.data      = bufv[0];
    end

    assign stream.ready = !flush_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            flush_reg <= 1'b0;
        end
        else if (step)
        begin
            cnt_reg   <= cnt_next;
            flush_reg <= flush_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            win_reg <= win_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("lookahead count above four");

    a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        flush_reg |-> cnt_reg != 3'd0)
        else $error("flush with empty window");

endmodule

// ===== rtl/core/anbs_evq.sv =====
// Two-entry event queue between the front end and the back end.
// Depends on anbs_pkg for the event type.

module anbs_evq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  anbs_pkg::anbs_evt_t evt_in,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output anbs_pkg::anbs_evt_t evt_out
);

    anbs_pkg::anbs_evt_t            ent_reg [anbs_pkg::EVQ_DEPTH];
    logic [anbs_pkg::EVQ_PTR_W-1:0] wr_ptr_reg;
    logic [anbs_pkg::EVQ_PTR_W-1:0] rd_ptr_reg;
    logic [anbs_pkg::EVQ_PTR_W:0]   cnt_reg;
    logic                           do_push;
    logic                           do_pop;

    assign full    = cnt_reg == (anbs_pkg::EVQ_PTR_W + 1)'(anbs_pkg::EVQ_DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign evt_out = ent_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= evt_in;
        end
    end

endmodule

// ===== rtl/core/anbs_back.sv =====
// Back end: tracks unit state, tags payload bytes and drives the output register.
// Depends on anbs_pkg and anbs_unit_if.

module anbs_back #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  anbs_pkg::anbs_evt_t evt,
    output logic                q_pop,
    anbs_unit_if.source         units
);

    logic                              in_unit_reg;
    logic                              in_unit_next;
    logic                              first_pend_reg;
    logic                              first_pend_next;
    logic [anbs_pkg::TYPE_W-1:0]       type_reg;
    logic [anbs_pkg::TYPE_W-1:0]       type_next;
    logic [LENGTH_BITS-1:0]            len_reg;
    logic [LENGTH_BITS-1:0]            len_next;
    logic [LENGTH_BITS-1:0]            len_inc;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [anbs_pkg::BYTE_W-1:0]       byte_reg;
    logic                              first_reg;
    logic                              last_reg;
    logic [anbs_pkg::TYPE_W-1:0]       otype_reg;
    logic [anbs_pkg::LEN_OUT_W-1:0]    olen_reg;
    logic                              take;
    logic                              emit;

    always_comb
    begin
        take  = !q_empty && (!out_valid_reg || units.ready);
        emit  = take && evt.pop && in_unit_reg;
        q_pop = take;

        in_unit_next    = in_unit_reg;
        first_pend_next = first_pend_reg;
        type_next       = type_reg;
        len_next        = len_reg;
        len_inc         = (len_reg == {LENGTH_BITS{1'b1}}) ? len_reg : len_reg + 1'b1;

        if (emit)
        begin
            if (first_pend_reg)
            begin
                type_next       = evt.data[anbs_pkg::TYPE_W-1:0] & anbs_pkg::TYPE_MASK;
                first_pend_next = 1'b0;
            end
            len_next = len_inc;
        end
        if (take && evt.strip)
        begin
            in_unit_next    = 1'b1;
            first_pend_next = 1'b1;
            len_next        = '0;
        end
        if (take && evt.end_unit)
        begin
            in_unit_next    = 1'b0;
            first_pend_next = 1'b0;
            len_next        = '0;
        end

        out_valid_next = emit || (out_valid_reg && !units.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_unit_reg    <= 1'b0;
            first_pend_reg <= 1'b0;
            type_reg       <= '0;
            len_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_unit_reg    <= in_unit_next;
            first_pend_reg <= first_pend_next;
            type_reg       <= (emit && first_pend_reg) ?
                              (evt.data[anbs_pkg::TYPE_W-1:0] & anbs_pkg::TYPE_MASK) : type_reg;
            len_reg        <= len_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg  <= evt.data;
            first_reg <= first_pend_reg;
            last_reg  <= evt.last_byte;
            otype_reg <= type_next;
            olen_reg  <= anbs_pkg::LEN_OUT_W'(len_inc);
        end
    end

    assign units.valid        = out_valid_reg;
    assign units.payload_byte = byte_reg;
    assign units.unit_first   = first_reg;
    assign units.unit_last    = last_reg;
    assign units.unit_type    = otype_reg;
    assign units.unit_length  = olen_reg;

    a_pend_in_unit: assert property (@(posedge clk) disable iff (!rst_n)
        first_pend_reg |-> in_unit_reg)
        else $error("first byte pending outside a unit");

    a_len_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_unit_reg |-> len_reg == '0)
        else $error("length count nonzero outside a unit");

    a_first_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && first_reg) |-> olen_reg == anbs_pkg::LEN_OUT_W'(1))
        else $error("first payload beat with length other than one");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for annexb_nal_unit_splitter: directed Annex B streams, then random ones.
// Depends on anbs_pkg, the three anbs_ channel interfaces and the splitter RTL.

module tb_top;

    localparam int LENGTH_BITS = 16;
    localparam int NORMAL_CAP = 24;

    typedef logic [anbs_pkg::BYTE_W-1:0] byte_seq_t [$];

    typedef struct {
        logic [anbs_pkg::BYTE_W-1:0] data;
        logic                        eos;
        int unsigned                 idle;
    } stream_beat_t;

    typedef struct packed {
        logic [anbs_pkg::BYTE_W-1:0]    payload;
        logic                           first;
        logic                           last;
        logic [anbs_pkg::TYPE_W-1:0]    utype;
        logic [anbs_pkg::LEN_OUT_W-1:0] ulen;
    } nal_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    anbs_byte_if stream_if ();
    anbs_cfg_if  cfg_if ();
    anbs_unit_if units_if ();

    annexb_nal_unit_splitter #(
        .LENGTH_BITS(LENGTH_BITS)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .cfg    (cfg_if),
        .units  (units_if)
    );

    stream_beat_t pending_bytes [$];
    nal_beat_t    expected_beats [$];
    int unsigned  error_count = 0;
    int unsigned  tx_cap = NORMAL_CAP;
    int unsigned  rx_cap = NORMAL_CAP;
    int unsigned  tx_idle;
    logic         tx_armed;
    int unsigned  rx_stall;
    stream_beat_t next_beat;
    nal_beat_t    got_beat;
    nal_beat_t    want_beat;

    // splitter state as seen from outside
    logic [anbs_pkg::BYTE_W-1:0] window [0:3];
    int                          window_cnt = 0;
    logic                        in_unit = 1'b0;
    logic                        first_pend = 1'b0;
    logic [anbs_pkg::TYPE_W-1:0] type_hold = '0;
    logic [LENGTH_BITS-1:0]      len_run = '0;
    logic                        three_byte_mode = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [anbs_pkg::CNT_W-1:0] code_at(
        input logic [anbs_pkg::BYTE_W-1:0] held [0:4],
        input int                          at,
        input int                          avail
    );
        if (avail >= 4 && held[at] == anbs_pkg::ZERO_BYTE &&
            held[at+1] == anbs_pkg::ZERO_BYTE && held[at+2] == anbs_pkg::ZERO_BYTE &&
            held[at+3] == anbs_pkg::ONE_BYTE)
            return anbs_pkg::LEN_CODE4;
        if (three_byte_mode && avail >= 3 && held[at] == anbs_pkg::ZERO_BYTE &&
            held[at+1] == anbs_pkg::ZERO_BYTE && held[at+2] == anbs_pkg::ONE_BYTE)
            return anbs_pkg::LEN_CODE3;
        return anbs_pkg::LEN_NONE;
    endfunction

    function automatic void split_byte(input logic [anbs_pkg::BYTE_W-1:0] data,
                                       input logic eos);
        logic [anbs_pkg::BYTE_W-1:0] held [0:4];
        int                          n;
        int                          head;
        logic [anbs_pkg::CNT_W-1:0]  clen;
        nal_beat_t                   beat;
        for (int k = 0; k < window_cnt; k++)
            held[k] = window[k];
        held[window_cnt] = data;
        n = window_cnt + 1;
        head = 0;
        while (head < n)
        begin
            clen = code_at(held, head, n - head);
            if (clen != anbs_pkg::LEN_NONE)
            begin
                head += int'(clen);
                in_unit = 1'b1;
                first_pend = 1'b1;
                len_run = '0;
            end
            else if (n - head >= 5 || eos)
            begin
                if (in_unit)
                begin
                    beat.payload = held[head];
                    beat.last = (n - head == 1) ||
                                (code_at(held, head + 1, n - head - 1) != anbs_pkg::LEN_NONE);
                    beat.first = first_pend;
                    if (first_pend)
                        type_hold = held[head][anbs_pkg::TYPE_W-1:0] & anbs_pkg::TYPE_MASK;
                    first_pend = 1'b0;
                    if (len_run != {LENGTH_BITS{1'b1}})
                        len_run++;
                    beat.utype = type_hold;
                    beat.ulen = len_run[anbs_pkg::LEN_OUT_W-1:0];
                    expected_beats.push_back(beat);
                end
                head++;
            end
            else
                break;
        end
        if (eos)
        begin
            window_cnt = 0;
            in_unit = 1'b0;
            first_pend = 1'b0;
            len_run = '0;
        end
        else
        begin
            for (int k = 0; k < n - head; k++)
                window[k] = held[head + k];
            window_cnt = n - head;
        end
    endfunction

    function automatic int unsigned pick_idle(input int unsigned cap);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (cap == 0 || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, (cap < 3) ? cap : 3);
        return $urandom_range(1, cap);
    endfunction

    function automatic logic [anbs_pkg::BYTE_W-1:0] random_payload();
        case ($urandom_range(0, 7))
            0, 1: return anbs_pkg::ZERO_BYTE;
            2: return anbs_pkg::ONE_BYTE;
            default: return anbs_pkg::BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_stream(input byte_seq_t seq);
        stream_beat_t item;
        foreach (seq[i])
        begin
            item.data = seq[i];
            item.eos = (i == seq.size() - 1);
            item.idle = pick_idle(tx_cap);
            pending_bytes.push_back(item);
        end
    endtask

    task automatic random_stream(input logic noise, output int count);
        byte_seq_t seq;
        if (noise)
        begin
            repeat ($urandom_range(4, 12))
                seq.push_back(anbs_pkg::BYTE_W'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 2))
                seq.push_back(anbs_pkg::BYTE_W'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 4))
            begin
                seq.push_back(anbs_pkg::ZERO_BYTE);
                seq.push_back(anbs_pkg::ZERO_BYTE);
                if ($urandom_range(0, 4) >= 2)
                    seq.push_back(anbs_pkg::ZERO_BYTE);
                seq.push_back(anbs_pkg::ONE_BYTE);
                repeat ($urandom_range(0, 7))
                    seq.push_back(random_payload());
            end
            // break off with a partial start code now and then
            case ($urandom_range(0, 5))
                0: repeat (2) seq.push_back(anbs_pkg::ZERO_BYTE);
                1: repeat (3) seq.push_back(anbs_pkg::ZERO_BYTE);
                default: ;
            endcase
        end
        send_stream(seq);
        count = seq.size();
    endtask

    task automatic random_phase(input int target);
        int total;
        int n;
        total = 0;
        while (total < target)
        begin
            random_stream($urandom_range(0, 5) == 0, n);
            total += n;
        end
    endtask

    task automatic drain();
        while (pending_bytes.size() != 0 || stream_if.valid || expected_beats.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.three_byte_codes <= mode;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        three_byte_mode = mode;
        cfg_if.valid <= 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : stream_driver
        if (!rst_n)
        begin
            stream_if.valid <= 1'b0;
            stream_if.data_byte <= '0;
            stream_if.end_of_stream <= 1'b0;
            tx_idle = 0;
            tx_armed = 1'b0;
        end
        else
        begin
            if (stream_if.valid && stream_if.ready)
                split_byte(stream_if.data_byte, stream_if.end_of_stream);
            if (!stream_if.valid || stream_if.ready)
            begin
                if (pending_bytes.size() != 0 && !tx_armed)
                begin
                    tx_idle = pending_bytes[0].idle;
                    tx_armed = 1'b1;
                end
                if (pending_bytes.size() == 0 || tx_idle != 0)
                begin
                    stream_if.valid <= 1'b0;
                    if (tx_idle != 0)
                        tx_idle--;
                end
                else
                begin
                    next_beat = pending_bytes.pop_front();
                    stream_if.valid <= 1'b1;
                    stream_if.data_byte <= next_beat.data;
                    stream_if.end_of_stream <= next_beat.eos;
                    tx_armed = 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : unit_monitor
        if (!rst_n)
        begin
            units_if.ready <= 1'b0;
            rx_stall = 0;
        end
        else
        begin
            if (units_if.valid && units_if.ready)
            begin
                got_beat = '{payload: units_if.payload_byte, first: units_if.unit_first,
                             last: units_if.unit_last, utype: units_if.unit_type,
                             ulen: units_if.unit_length};
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: beat with none expected, actual byte %02h first %0b %s",
                             $time, got_beat.payload, got_beat.first,
                             $sformatf("last %0b type %0d length %0d",
                                       got_beat.last, got_beat.utype, got_beat.ulen));
                    error_count++;
                end
                else
                begin
                    want_beat = expected_beats.pop_front();
                    if (got_beat !== want_beat)
                    begin
                        $display("%0t: expected byte %02h first %0b last %0b %s",
                                 $time, want_beat.payload, want_beat.first, want_beat.last,
                                 $sformatf("type %0d length %0d",
                                           want_beat.utype, want_beat.ulen));
                        $display("%0t: actual   byte %02h first %0b last %0b %s",
                                 $time, got_beat.payload, got_beat.first, got_beat.last,
                                 $sformatf("type %0d length %0d",
                                           got_beat.utype, got_beat.ulen));
                        error_count++;
                    end
                end
            end
            if (rx_stall != 0)
            begin
                rx_stall--;
                units_if.ready <= 1'b0;
            end
            else
            begin
                units_if.ready <= 1'b1;
                rx_stall = pick_idle(rx_cap);
            end
        end
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.three_byte_codes = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // leading garbage, zero before a start code, 00 00 01 ignored, partial code at end
        write_mode(1'b0);
        send_stream('{8'hab, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'hff, 8'h00, 8'h00,
                      8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h80, 8'h00, 8'h00});
        drain();

        // three-byte codes, empty unit, single-byte unit at end of stream
        write_mode(1'b1);
        send_stream('{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'he7, 8'h00, 8'h00,
                      8'h00, 8'h01, 8'h42});
        drain();

        tx_cap = 0;
        rx_cap = 0;
        random_phase(28);
        drain();

        tx_cap = NORMAL_CAP;
        rx_cap = NORMAL_CAP;
        write_mode(1'b0);
        random_phase(28);
        drain();

        write_mode(1'b1);
        random_phase(28);
        drain();

        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_beats.size() == 0)
        begin
            $display("[annexb_nal_unit_splitter] OK");
        end
        else
        begin
            $display("[annexb_nal_unit_splitter] ERROR");
        end
        $finish;
    end

    initial
    begin
        #500_000;
        $display("[annexb_nal_unit_splitter] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/anbs_pkg.sv
rtl/core/anbs_byte_if.sv
rtl/core/anbs_unit_if.sv
rtl/core/anbs_cfg_if.sv
rtl/core/anbs_front.sv
rtl/core/anbs_evq.sv
rtl/core/anbs_back.sv
rtl/core/annexb_nal_unit_splitter.sv
tb/tb_top.sv
